>>> src/sidc_pkg.sv
// sidc_pkg: widths, character codes and controller types for the
// signed integer to decimal text converter; no dependencies
`timescale 1ns / 1ps

package sidc_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int IN_WIDTH    = 32;
    localparam int CHAR_WIDTH  = 8;
    localparam int DIGIT_WIDTH = 4;
    localparam int RADIX       = 10;
    // decimal digits of 2**(VALUE_WIDTH-1), rounded up
    localparam int DIGITS_MAX  = (VALUE_WIDTH * 3 + 9) / 10;
    localparam int IDX_WIDTH   = $clog2(DIGITS_MAX);
    localparam int CNT_WIDTH   = $clog2(DIGITS_MAX + 1);

    // divide by ten: q = (x * RECIP) >> RECIP_SHIFT, exact for 32-bit x
    localparam int          DIV_WIDTH   = 32;
    localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;      // take a new value
        logic step;      // one divide by ten
        logic pop;       // one digit sent
        logic sel_sign;  // drive the minus sign
    } t_dp_cmd;

    typedef struct packed {
        logic neg;       // value is negative
        logic q_zero;    // quotient of this step is zero
        logic last;      // one digit left in the stack
    } t_dp_status;

endpackage

>>> src/sidc_in_if.sv
// sidc_in_if: input request channel carrying one signed value
// depends on sidc_pkg
`timescale 1ns / 1ps

interface sidc_in_if;
    import sidc_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [IN_WIDTH-1:0]   value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> src/sidc_out_if.sv
// sidc_out_if: output request channel carrying one character and a last flag
// depends on sidc_pkg
`timescale 1ns / 1ps

interface sidc_out_if;
    import sidc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CHAR_WIDTH-1:0]   char_code;
    logic                    last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

>>> src/signed_int_to_decimal_chars.sv
// Signed integer to decimal ASCII converter.
// Input channel i_in carries one signed 32-bit value per request; only the
// low VALUE_WIDTH bits are used, as a signed number of that width.
// Output channel o_out carries the decimal text one character per request,
// most significant digit first: an optional '-' and then 1 to 10 digits.
// last_char marks the final character; no terminating zero is sent.
// One value at a time: i_in.ready is high only while the block is idle.
// After acceptance the magnitude is divided by ten once per cycle (one
// reciprocal multiply per step), one step per digit, filling a digit
// stack; the characters then leave one per cycle while o_out.ready is high.
// A stalled receiver simply holds the current character and state.
// Synchronous active-low reset returns the controller to idle; the run
// in progress is dropped. There is no configuration.
// depends on sidc_pkg, sidc_in_if, sidc_out_if, sidc_ctrl, sidc_dp
`timescale 1ns / 1ps

module signed_int_to_decimal_chars (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sidc_in_if.sink           i_in,
    sidc_out_if.source        o_out
);
    import sidc_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    sidc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    sidc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_value     (i_in.value),
        .o_status    (w_status),
        .o_char_code (o_out.char_code),
        .o_last_char (o_out.last_char)
    );

endmodule

>>> src/sidc_dp.sv
// sidc_dp: magnitude register, divide-by-ten step and digit stack
// depends on sidc_pkg
`timescale 1ns / 1ps

module sidc_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  sidc_pkg::t_dp_cmd                       i_cmd,
    input  logic signed [sidc_pkg::IN_WIDTH-1:0]    i_value,
    output sidc_pkg::t_dp_status                    o_status,
    output logic [sidc_pkg::CHAR_WIDTH-1:0]         o_char_code,
    output logic                                    o_last_char
);
    import sidc_pkg::*;

    logic [VALUE_WIDTH-1:0]   r_mag, n_mag;
    logic                     r_neg, n_neg;
    logic [CNT_WIDTH-1:0]     r_nd, n_nd;
    logic [DIGIT_WIDTH-1:0]   r_digits [DIGITS_MAX];

    logic [VALUE_WIDTH-1:0]   w_raw;
    logic [DIV_WIDTH-1:0]     w_mag_ext;
    logic [2*DIV_WIDTH-1:0]   w_prod;
    logic [DIV_WIDTH-1:0]     w_q;
    logic [DIV_WIDTH-1:0]     w_q10;
    logic [DIGIT_WIDTH-1:0]   w_rem;
    logic [IDX_WIDTH-1:0]     w_wr_idx;
    logic [IDX_WIDTH-1:0]     w_rd_idx;
    logic [DIGIT_WIDTH-1:0]   w_digit;

    assign w_raw     = w_raw_sel(i_value);
    assign w_mag_ext = DIV_WIDTH'(r_mag);
    assign w_prod    = w_mag_ext * RECIP;
    assign w_q       = DIV_WIDTH'(w_prod[2*DIV_WIDTH-1:RECIP_SHIFT]);
    assign w_q10     = (w_q << 3) + (w_q << 1);
    assign w_rem     = DIGIT_WIDTH'(w_mag_ext - w_q10);
    assign w_wr_idx  = r_nd[IDX_WIDTH-1:0];
    assign w_rd_idx  = IDX_WIDTH'(r_nd - 1'b1);
    assign w_digit   = r_digits[w_rd_idx];

    function automatic logic [VALUE_WIDTH-1:0] w_raw_sel(
        input logic signed [IN_WIDTH-1:0] v
    );
        w_raw_sel = v[VALUE_WIDTH-1:0];
    endfunction

    always_comb begin
        n_mag = r_mag;
        n_neg = r_neg;
        n_nd  = r_nd;
        if (i_cmd.load) begin
            n_neg = w_raw[VALUE_WIDTH-1];
            // unsigned magnitude, so the most negative value stays correct
            n_mag = w_raw[VALUE_WIDTH-1] ? (~w_raw + 1'b1) : w_raw;
            n_nd  = '0;
        end else if (i_cmd.step) begin
            n_mag = VALUE_WIDTH'(w_q);
            n_nd  = r_nd + 1'b1;
        end else if (i_cmd.pop) begin
            n_nd  = r_nd - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nd <= '0;
        end else begin
            r_nd <= n_nd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_neg <= n_neg;
        if (i_cmd.step) begin
            r_digits[w_wr_idx] <= w_rem;
        end
    end

    assign o_status.neg    = r_neg;
    assign o_status.q_zero = (w_q == '0);
    assign o_status.last   = (r_nd == CNT_WIDTH'(1));

    assign o_char_code = i_cmd.sel_sign ? CHAR_MINUS
                                        : CHAR_ZERO + CHAR_WIDTH'(w_digit);
    assign o_last_char = !i_cmd.sel_sign && (r_nd == CNT_WIDTH'(1));

endmodule

>>> src/sidc_ctrl.sv
// sidc_ctrl: controller state machine sequencing load, divide and emit
// depends on sidc_pkg
`timescale 1ns / 1ps

module sidc_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output sidc_pkg::t_dp_cmd      o_cmd,
    input  sidc_pkg::t_dp_status   i_status
);
    import sidc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                // zero magnitude still yields one digit on the first step
                o_cmd.step = 1'b1;
                if (i_status.q_zero) begin
                    n_state = i_status.neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                o_out_valid    = 1'b1;
                o_cmd.sel_sign = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.pop = 1'b1;
                    if (i_status.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/sidc_chk.sv
// sidc_chk: port-level checks for the decimal text converter, bound to the top
// depends on sidc_pkg and signed_int_to_decimal_chars
`timescale 1ns / 1ps

module sidc_chk (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [sidc_pkg::CHAR_WIDTH-1:0]    i_char_code,
    input  logic                               i_last_char
);
    import sidc_pkg::*;

    // a stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_char_code) && $stable(i_last_char))
        else $error("stalled character changed");

    // one value at a time
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input taken while a run is being sent");

    // at least one divide step before the first character
    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_out_valid)
        else $error("character sent right after acceptance");

    // end of run frees the input
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_last_char |=> i_in_ready)
        else $error("not ready after last character");

    // the sign never ends a run
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_char_code == CHAR_MINUS) |-> !i_last_char)
        else $error("run ended on a minus sign");

endmodule

bind signed_int_to_decimal_chars sidc_chk u_sidc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_char_code (o_out.char_code),
    .i_last_char (o_out.last_char)
);
